// File: design/tbw_pkg.sv
// Shared widths, constants and types of the barycentric weight block.
`default_nettype none

package tbw_pkg;

    localparam int WFRAC = 16;                  // fraction bits of a weight

    localparam int CW    = 16;                  // coordinate width, signed Q8.8
    localparam int DW    = CW + 1;              // edge vector component
    localparam int DPW   = 2 * DW;              // one component product
    localparam int DOTW  = DPW + 1;             // dot product, signed
    localparam int MAGW  = DOTW - 1;            // dot product magnitude
    localparam int HALF  = MAGW / 2;            // low slice of a split operand
    localparam int HIW   = MAGW - HALF;         // high slice of a split operand
    localparam int PPW   = 2 * HIW;             // partial product
    localparam int PMAGW = 2 * MAGW;            // magnitude of a wide product
    localparam int SPW   = PMAGW + 1;           // signed wide product
    localparam int DENW  = SPW + 1;             // denom, nu, nv
    localparam int SUMW  = DENW + 1;            // nu + nv
    localparam int NPROD = 6;                   // ac, bb, cd, be, ae, bd

    localparam int WW    = 20;                  // weight width
    localparam int QB    = WW + 1;              // quotient bits kept by the divider
    localparam int RW    = DENW + WFRAC + QB;   // divider remainder width
    localparam int AW    = ((WFRAC + 1 > WW) ? WFRAC + 1 : WW) + 2;

    localparam int MQD   = 8;                   // queue between front and back
    localparam int MQAW  = $clog2(MQD);
    localparam int MQCW  = $clog2(MQD + 1);
    localparam int OQD   = 32;                  // result queue
    localparam int OQAW  = $clog2(OQD);
    localparam int OQCW  = $clog2(OQD + 1);

    localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};
    localparam logic signed [AW-1:0] ONE_AW = AW'(64'd1 << WFRAC);
    localparam logic signed [WW-1:0] W_ONE =
        (WFRAC >= WW - 1) ? W_MAX : WW'(64'd1 << WFRAC);
    localparam logic [QB-1:0] Q_POS_MAX = QB'((64'd1 << (WW - 1)) - 64'd1);
    localparam logic [QB-1:0] Q_NEG_MAX = QB'(64'd1 << (WW - 1));

    typedef struct packed {
        logic at_a;
        logic at_b;
        logic at_c;
    } t_match;

    typedef struct packed {
        logic signed [DOTW-1:0] a;
        logic signed [DOTW-1:0] b;
        logic signed [DOTW-1:0] c;
        logic signed [DOTW-1:0] d;
        logic signed [DOTW-1:0] e;
        t_match                 m;
    } t_mid;

    typedef struct packed {
        t_match m;
        logic   degen;
        logic   in_tri;
        logic   neg_u;
        logic   neg_v;
    } t_side;

    typedef struct packed {
        logic signed [WW-1:0] w_a;
        logic signed [WW-1:0] w_b;
        logic signed [WW-1:0] w_c;
        logic                 in_tri;
        logic                 degen;
    } t_res;

endpackage

`default_nettype wire

// File: design/tbw_front.sv
// Front part: accept items, form edge vectors, vertex matches and dot products.
`default_nettype none

module tbw_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_pop_mid,
    input  logic signed [tbw_pkg::CW-1:0] i_pt_x,
    input  logic signed [tbw_pkg::CW-1:0] i_pt_y,
    input  logic signed [tbw_pkg::CW-1:0] i_pt_z,
    input  logic signed [tbw_pkg::CW-1:0] i_va_x,
    input  logic signed [tbw_pkg::CW-1:0] i_va_y,
    input  logic signed [tbw_pkg::CW-1:0] i_va_z,
    input  logic signed [tbw_pkg::CW-1:0] i_vb_x,
    input  logic signed [tbw_pkg::CW-1:0] i_vb_y,
    input  logic signed [tbw_pkg::CW-1:0] i_vb_z,
    input  logic signed [tbw_pkg::CW-1:0] i_vc_x,
    input  logic signed [tbw_pkg::CW-1:0] i_vc_y,
    input  logic signed [tbw_pkg::CW-1:0] i_vc_z,
    output logic                       o_full,
    output logic                       o_push,
    output tbw_pkg::t_mid              o_entry
);
    import tbw_pkg::*;

    logic signed [CW-1:0] w_pt [3];
    logic signed [CW-1:0] w_va [3];
    logic signed [CW-1:0] w_vb [3];
    logic signed [CW-1:0] w_vc [3];
    logic                 w_acc;
    t_match               w_m;

    logic signed [DW-1:0]  r1_e0 [3];
    logic signed [DW-1:0]  r1_e1 [3];
    logic signed [DW-1:0]  r1_e2 [3];
    t_match                r1_m;
    logic                  r1_v;
    logic signed [DPW-1:0] r2_paa [3];
    logic signed [DPW-1:0] r2_pab [3];
    logic signed [DPW-1:0] r2_pbb [3];
    logic signed [DPW-1:0] r2_pda [3];
    logic signed [DPW-1:0] r2_pdb [3];
    t_match                r2_m;
    logic                  r2_v;
    logic [MQCW-1:0]       r_fcred;
    logic [MQCW-1:0]       n_fcred;

    always_comb begin
        w_pt[0] = i_pt_x; w_pt[1] = i_pt_y; w_pt[2] = i_pt_z;
        w_va[0] = i_va_x; w_va[1] = i_va_y; w_va[2] = i_va_z;
        w_vb[0] = i_vb_x; w_vb[1] = i_vb_y; w_vb[2] = i_vb_z;
        w_vc[0] = i_vc_x; w_vc[1] = i_vc_y; w_vc[2] = i_vc_z;
        w_m.at_a = (w_pt[0] == w_va[0]) && (w_pt[1] == w_va[1]) && (w_pt[2] == w_va[2]);
        w_m.at_b = (w_pt[0] == w_vb[0]) && (w_pt[1] == w_vb[1]) && (w_pt[2] == w_vb[2]);
        w_m.at_c = (w_pt[0] == w_vc[0]) && (w_pt[1] == w_vc[1]) && (w_pt[2] == w_vc[2]);
    end

    // Credit covers both front stages and the queue, so the front never stalls.
    assign o_full = (r_fcred == MQCW'(MQD));
    assign w_acc  = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_e0[i]  <= DW'(w_vb[i]) - DW'(w_va[i]);
            r1_e1[i]  <= DW'(w_vc[i]) - DW'(w_va[i]);
            r1_e2[i]  <= DW'(w_pt[i]) - DW'(w_va[i]);
            r2_paa[i] <= DPW'(r1_e0[i]) * DPW'(r1_e0[i]);
            r2_pab[i] <= DPW'(r1_e0[i]) * DPW'(r1_e1[i]);
            r2_pbb[i] <= DPW'(r1_e1[i]) * DPW'(r1_e1[i]);
            r2_pda[i] <= DPW'(r1_e2[i]) * DPW'(r1_e0[i]);
            r2_pdb[i] <= DPW'(r1_e2[i]) * DPW'(r1_e1[i]);
        end
        r1_m <= w_m;
        r2_m <= r1_m;
    end

    always_comb begin
        n_fcred = r_fcred;
        if (w_acc && !i_pop_mid) begin
            n_fcred = r_fcred + MQCW'(1);
        end else if (!w_acc && i_pop_mid) begin
            n_fcred = r_fcred - MQCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_fcred <= '0;
        end else begin
            r1_v    <= w_acc;
            r2_v    <= r1_v;
            r_fcred <= n_fcred;
        end
    end

    assign o_push    = r2_v;
    assign o_entry.a = DOTW'(r2_paa[0]) + DOTW'(r2_paa[1]) + DOTW'(r2_paa[2]);
    assign o_entry.b = DOTW'(r2_pab[0]) + DOTW'(r2_pab[1]) + DOTW'(r2_pab[2]);
    assign o_entry.c = DOTW'(r2_pbb[0]) + DOTW'(r2_pbb[1]) + DOTW'(r2_pbb[2]);
    assign o_entry.d = DOTW'(r2_pda[0]) + DOTW'(r2_pda[1]) + DOTW'(r2_pda[2]);
    assign o_entry.e = DOTW'(r2_pdb[0]) + DOTW'(r2_pdb[1]) + DOTW'(r2_pdb[2]);
    assign o_entry.m = r2_m;

endmodule

`default_nettype wire

// File: design/tbw_queue.sv
// Short queue of dot-product sets between the front and the back.
`default_nettype none

module tbw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tbw_pkg::t_mid i_entry,
    input  logic          i_pop,
    output logic          o_empty,
    output tbw_pkg::t_mid o_head
);
    import tbw_pkg::*;

    t_mid            r_mem [MQD];
    logic [MQAW-1:0] r_wp;
    logic [MQAW-1:0] r_rp;
    logic [MQCW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + MQAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + MQAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + MQCW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - MQCW'(1);
            end
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

endmodule

`default_nettype wire

// File: design/tbw_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none

module tbw_div (
    input  logic                     i_clk,
    input  logic [tbw_pkg::RW-1:0]   i_num,
    input  logic [tbw_pkg::RW-1:0]   i_den,
    output logic [tbw_pkg::QB-1:0]   o_quot,
    output logic                     o_ovf
);
    import tbw_pkg::*;

    logic [RW-1:0] r_rem [QB];
    logic [RW-1:0] r_dvs [QB];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];

    // Quotient too large for the kept bits: flag it and let saturation take over.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_dvs[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= (i_num >= (i_den << QB));
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        localparam int K = QB - s;
        logic [RW-1:0] w_t;
        logic          w_ge;

        assign w_t  = r_dvs[s-1] << K;
        assign w_ge = (r_rem[s-1] >= w_t);

        always_ff @(posedge i_clk) begin
            r_q[s]   <= r_q[s-1] | (QB'(w_ge) << K);
            r_ovf[s] <= r_ovf[s-1];
        end

        if (s < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_ge ? (r_rem[s-1] - w_t) : r_rem[s-1];
                r_dvs[s] <= r_dvs[s-1];
            end
        end
    end

    assign o_quot = r_q[QB];
    assign o_ovf  = r_ovf[QB];

endmodule

`default_nettype wire

// File: design/tbw_back.sv
// Back part: wide products, denominators, division, weights and result queue.
`default_nettype none

module tbw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  tbw_pkg::t_mid                 i_head,
    output logic                          o_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic signed [tbw_pkg::WW-1:0] o_weight_a,
    output logic signed [tbw_pkg::WW-1:0] o_weight_b,
    output logic signed [tbw_pkg::WW-1:0] o_weight_c,
    output logic                          o_inside_res,
    output logic                          o_degenerate
);
    import tbw_pkg::*;

    localparam int LAT = QB + 8;

    function automatic logic [MAGW-1:0] f_mag(logic signed [DOTW-1:0] v);
        return v[DOTW-1] ? MAGW'(-v) : v[MAGW-1:0];
    endfunction

    function automatic logic signed [WW-1:0] f_ratio(logic [QB-1:0] q, logic ovf,
                                                     logic neg);
        logic [QB-1:0] nq;
        nq = '0 - q;
        if (!neg) begin
            return (ovf || (q > Q_POS_MAX)) ? W_MAX : q[WW-1:0];
        end
        return (ovf || (q > Q_NEG_MAX)) ? W_MIN : nq[WW-1:0];
    endfunction

    logic              w_issue;
    logic              w_opop;
    logic [LAT-1:0]    r_vld;
    logic [OQCW-1:0]   r_cred;

    // Stage 0: magnitudes
    logic [MAGW-1:0]   r0_ma, r0_mb, r0_mc, r0_md, r0_me;
    logic              r0_sb, r0_sd, r0_se;
    t_match            r0_m;
    // Stage 1: partial products
    logic [MAGW-1:0]   w_x  [NPROD];
    logic [MAGW-1:0]   w_y  [NPROD];
    logic              w_sg [NPROD];
    logic [PPW-1:0]    r1_ll [NPROD];
    logic [PPW-1:0]    r1_lh [NPROD];
    logic [PPW-1:0]    r1_hl [NPROD];
    logic [PPW-1:0]    r1_hh [NPROD];
    logic              r1_sg [NPROD];
    t_match            r1_m;
    // Stage 2..4
    logic [PMAGW-1:0]       r2_pm [NPROD];
    logic                   r2_sg [NPROD];
    t_match                 r2_m;
    logic signed [SPW-1:0]  r3_ps [NPROD];
    t_match                 r3_m;
    logic signed [DENW-1:0] r4_den, r4_nu, r4_nv;
    t_match                 r4_m;
    // Stage 5: classification and divider operands
    logic signed [SUMW-1:0] w_sum;
    logic [DENW-1:0]        w_mu, w_mv;
    t_side                  w_side;
    logic [RW-1:0]          r5_nu, r5_nv, r5_den;
    t_side                  r5_side;
    // Divider and final stages
    logic [QB-1:0]          w_qu, w_qv;
    logic                   w_ou, w_ov;
    t_side                  r_dside [QB+1];
    logic signed [WW-1:0]   r6_w1, r6_w2;
    t_side                  r6_side;
    logic signed [AW-1:0]   w_s;
    logic signed [WW-1:0]   w_w0;
    t_res                   w_res;

    t_res                   r_oq [OQD];
    logic [OQAW-1:0]        r_owp, r_orp;
    logic [OQCW-1:0]        r_ocnt;

    // Issue only with room reserved in the result queue: the pipe never stalls.
    assign w_issue = !i_empty && (r_cred < OQCW'(OQD));
    assign o_pop   = w_issue;
    assign w_opop  = i_pop && (r_ocnt != '0);

    always_ff @(posedge i_clk) begin
        r0_ma <= f_mag(i_head.a);
        r0_mb <= f_mag(i_head.b);
        r0_mc <= f_mag(i_head.c);
        r0_md <= f_mag(i_head.d);
        r0_me <= f_mag(i_head.e);
        r0_sb <= i_head.b[DOTW-1];
        r0_sd <= i_head.d[DOTW-1];
        r0_se <= i_head.e[DOTW-1];
        r0_m  <= i_head.m;
    end

    always_comb begin
        w_x[0] = r0_ma; w_y[0] = r0_mc; w_sg[0] = 1'b0;
        w_x[1] = r0_mb; w_y[1] = r0_mb; w_sg[1] = 1'b0;
        w_x[2] = r0_mc; w_y[2] = r0_md; w_sg[2] = r0_sd;
        w_x[3] = r0_mb; w_y[3] = r0_me; w_sg[3] = r0_sb ^ r0_se;
        w_x[4] = r0_ma; w_y[4] = r0_me; w_sg[4] = r0_se;
        w_x[5] = r0_mb; w_y[5] = r0_md; w_sg[5] = r0_sb ^ r0_sd;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NPROD; k++) begin
            r1_ll[k] <= PPW'(w_x[k][HALF-1:0]) * PPW'(w_y[k][HALF-1:0]);
            r1_lh[k] <= PPW'(w_x[k][HALF-1:0]) * PPW'(w_y[k][MAGW-1:HALF]);
            r1_hl[k] <= PPW'(w_x[k][MAGW-1:HALF]) * PPW'(w_y[k][HALF-1:0]);
            r1_hh[k] <= PPW'(w_x[k][MAGW-1:HALF]) * PPW'(w_y[k][MAGW-1:HALF]);
            r1_sg[k] <= w_sg[k];
            r2_pm[k] <= PMAGW'(r1_ll[k]) + (PMAGW'(r1_lh[k]) << HALF)
                      + (PMAGW'(r1_hl[k]) << HALF) + (PMAGW'(r1_hh[k]) << (2 * HALF));
            r2_sg[k] <= r1_sg[k];
            r3_ps[k] <= r2_sg[k] ? -SPW'(r2_pm[k]) : SPW'(r2_pm[k]);
        end
        r1_m   <= r0_m;
        r2_m   <= r1_m;
        r3_m   <= r2_m;
        r4_den <= DENW'(r3_ps[0]) - DENW'(r3_ps[1]);
        r4_nu  <= DENW'(r3_ps[2]) - DENW'(r3_ps[3]);
        r4_nv  <= DENW'(r3_ps[4]) - DENW'(r3_ps[5]);
        r4_m   <= r3_m;
    end

    always_comb begin
        w_sum        = SUMW'(r4_nu) + SUMW'(r4_nv);
        w_side.m     = r4_m;
        w_side.degen = r4_den[DENW-1] || (r4_den == '0);
        w_side.neg_u = r4_nu[DENW-1];
        w_side.neg_v = r4_nv[DENW-1];
        w_side.in_tri = !w_side.degen && !w_side.neg_u && !w_side.neg_v
                     && (w_sum < SUMW'(r4_den));
        w_mu = r4_nu[DENW-1] ? DENW'(-r4_nu) : r4_nu[DENW-1:0];
        w_mv = r4_nv[DENW-1] ? DENW'(-r4_nv) : r4_nv[DENW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r5_nu   <= RW'(w_mu) << WFRAC;
        r5_nv   <= RW'(w_mv) << WFRAC;
        r5_den  <= RW'(r4_den[DENW-1:0]);
        r5_side <= w_side;
    end

    tbw_div u_div_u (
        .i_clk  (i_clk),
        .i_num  (r5_nu),
        .i_den  (r5_den),
        .o_quot (w_qu),
        .o_ovf  (w_ou)
    );

    tbw_div u_div_v (
        .i_clk  (i_clk),
        .i_num  (r5_nv),
        .i_den  (r5_den),
        .o_quot (w_qv),
        .o_ovf  (w_ov)
    );

    always_ff @(posedge i_clk) begin
        r_dside[0] <= r5_side;
        for (int j = 1; j <= QB; j++) begin
            r_dside[j] <= r_dside[j-1];
        end
        r6_w1   <= f_ratio(w_qu, w_ou, r_dside[QB].neg_u);
        r6_w2   <= f_ratio(w_qv, w_ov, r_dside[QB].neg_v);
        r6_side <= r_dside[QB];
    end

    always_comb begin
        w_s  = ONE_AW - AW'(r6_w1) - AW'(r6_w2);
        w_w0 = (w_s > AW'(W_MAX)) ? W_MAX :
               (w_s < AW'(W_MIN)) ? W_MIN : w_s[WW-1:0];
        w_res.in_tri = r6_side.in_tri;
        w_res.degen  = r6_side.degen;
        if (r6_side.m.at_a || (!r6_side.m.at_b && !r6_side.m.at_c && r6_side.degen)) begin
            w_res.w_a = W_ONE; w_res.w_b = '0;    w_res.w_c = '0;
        end else if (r6_side.m.at_b) begin
            w_res.w_a = '0;    w_res.w_b = W_ONE; w_res.w_c = '0;
        end else if (r6_side.m.at_c) begin
            w_res.w_a = '0;    w_res.w_b = '0;    w_res.w_c = W_ONE;
        end else begin
            w_res.w_a = w_w0;  w_res.w_b = r6_w1; w_res.w_c = r6_w2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[LAT-1]) begin
            r_oq[r_owp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_cred <= '0;
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_issue};
            if (w_issue && !w_opop) begin
                r_cred <= r_cred + OQCW'(1);
            end else if (!w_issue && w_opop) begin
                r_cred <= r_cred - OQCW'(1);
            end
            if (r_vld[LAT-1]) begin
                r_owp <= r_owp + OQAW'(1);
            end
            if (w_opop) begin
                r_orp <= r_orp + OQAW'(1);
            end
            if (r_vld[LAT-1] && !w_opop) begin
                r_ocnt <= r_ocnt + OQCW'(1);
            end else if (!r_vld[LAT-1] && w_opop) begin
                r_ocnt <= r_ocnt - OQCW'(1);
            end
        end
    end

    assign o_empty      = (r_ocnt == '0);
    assign o_weight_a   = r_oq[r_orp].w_a;
    assign o_weight_b   = r_oq[r_orp].w_b;
    assign o_weight_c   = r_oq[r_orp].w_c;
    assign o_inside_res = r_oq[r_orp].in_tri;
    assign o_degenerate = r_oq[r_orp].degen;

endmodule

`default_nettype wire

// File: design/triangle_barycentric_weights.sv
// Top level of the barycentric weight block: front, queue and back.
//
//   channel   direction  handshake           beat
//   input     in         push / full         point and three vertices, Q8.8
//   result    out        empty / pop         three Q4.16 weights, inside, degenerate
//
// One beat per clock in and out, sustained while full stays low and results are popped.
// A beat reaches the result queue through the front stages, the middle queue and the
// back; most of the back is the 21-stage divider, which yields one quotient bit per stage.
// Reset clears only control state (valid bits, pointers, credit and occupancy counters).
// Both sides stall on their own: the front holds full only when the middle
// queue is spoken for, and the back issues only with a result slot reserved.
`default_nettype none

module triangle_barycentric_weights (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [tbw_pkg::CW-1:0] i_pt_x,
    input  logic signed [tbw_pkg::CW-1:0] i_pt_y,
    input  logic signed [tbw_pkg::CW-1:0] i_pt_z,
    input  logic signed [tbw_pkg::CW-1:0] i_va_x,
    input  logic signed [tbw_pkg::CW-1:0] i_va_y,
    input  logic signed [tbw_pkg::CW-1:0] i_va_z,
    input  logic signed [tbw_pkg::CW-1:0] i_vb_x,
    input  logic signed [tbw_pkg::CW-1:0] i_vb_y,
    input  logic signed [tbw_pkg::CW-1:0] i_vb_z,
    input  logic signed [tbw_pkg::CW-1:0] i_vc_x,
    input  logic signed [tbw_pkg::CW-1:0] i_vc_y,
    input  logic signed [tbw_pkg::CW-1:0] i_vc_z,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [tbw_pkg::WW-1:0] o_weight_a,
    output logic signed [tbw_pkg::WW-1:0] o_weight_b,
    output logic signed [tbw_pkg::WW-1:0] o_weight_c,
    output logic                          o_inside_res,
    output logic                          o_degenerate
);
    import tbw_pkg::*;

    logic w_push_mid;   // front drops a dot-product set into the queue
    logic w_pop_mid;    // back takes the oldest set
    logic w_mid_empty;
    t_mid w_entry;
    t_mid w_head;

    // Edge vectors, vertex matches and the five dot products.
    tbw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop_mid (w_pop_mid),
        .i_pt_x    (i_pt_x),
        .i_pt_y    (i_pt_y),
        .i_pt_z    (i_pt_z),
        .i_va_x    (i_va_x),
        .i_va_y    (i_va_y),
        .i_va_z    (i_va_z),
        .i_vb_x    (i_vb_x),
        .i_vb_y    (i_vb_y),
        .i_vb_z    (i_vb_z),
        .i_vc_x    (i_vc_x),
        .i_vc_y    (i_vc_y),
        .i_vc_z    (i_vc_z),
        .o_full    (full),
        .o_push    (w_push_mid),
        .o_entry   (w_entry)
    );

    // Decouple the two halves.
    tbw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push_mid),
        .i_entry (w_entry),
        .i_pop   (w_pop_mid),
        .o_empty (w_mid_empty),
        .o_head  (w_head)
    );

    // Determinants, exact inside test, division, saturation and the result queue.
    tbw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_mid_empty),
        .i_head       (w_head),
        .o_pop        (w_pop_mid),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_weight_a   (o_weight_a),
        .o_weight_b   (o_weight_b),
        .o_weight_c   (o_weight_c),
        .o_inside_res (o_inside_res),
        .o_degenerate (o_degenerate)
    );

endmodule

`default_nettype wire
